// File: rtl/core/fisa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fisa_pkg;

  localparam int unsigned SLOT_COUNT_DEF       = 1024;
  localparam int unsigned INTERVAL_ENTRIES_DEF = 16;
  localparam int unsigned IDX_W                = 10;

  typedef enum logic [0:0] {
    OP_CLAIM   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // handed from one cell to the next
  typedef struct packed {
    logic             claim_done;
    logic             match_done;
    logic             free_done;
    logic [IDX_W-1:0] grant_idx;
  } chain_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] granted_index;
    logic             table_overflow;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/fisa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fisa_cell #(
  parameter int unsigned        BoundW    = 11,
  parameter logic               RstActive = 1'b0,
  parameter logic [BoundW-1:0]  RstEnd    = '0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          operation_i,
  input  wire logic [fisa_pkg::IDX_W-1:0]    release_index_i,
  input  wire logic                          any_match_i,
  input  wire fisa_pkg::chain_t              chain_i,
  output fisa_pkg::chain_t                   chain_o
);
  import fisa_pkg::*;

  logic              active_q, active_d;
  logic [BoundW-1:0] start_q, start_d;
  logic [BoundW-1:0] end_q, end_d;

  logic [BoundW-1:0] slot_ext, slot_inc, start_inc;
  logic              is_rel, claim_hit, lo_hit, hi_hit, rel_ok, open_hit;

  assign is_rel    = (operation_i == OP_RELEASE);
  assign slot_ext  = BoundW'(release_index_i);
  assign slot_inc  = slot_ext + BoundW'(1);
  assign start_inc = start_q + BoundW'(1);

  assign claim_hit = accept_i & ~is_rel & active_q & ~chain_i.claim_done;
  assign lo_hit    = active_q & (slot_inc == start_q);
  assign hi_hit    = active_q & (end_q == slot_ext);
  assign rel_ok    = accept_i & is_rel & ~chain_i.match_done;
  assign open_hit  = accept_i & is_rel & ~active_q & ~chain_i.free_done & ~any_match_i;

  always_comb begin
    active_d = active_q;
    start_d  = start_q;
    end_d    = end_q;
    priority if (claim_hit) begin
      start_d = start_inc;
      if (start_inc >= end_q) begin
        active_d = 1'b0;
      end
    end else if (rel_ok && lo_hit) begin
      start_d = slot_ext;
    end else if (rel_ok && hi_hit) begin
      end_d = slot_inc;
    end else if (open_hit) begin
      start_d  = slot_ext;
      end_d    = slot_inc;
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= RstActive;
      start_q  <= '0;
      end_q    <= RstEnd;
    end else begin
      active_q <= active_d;
      start_q  <= start_d;
      end_q    <= end_d;
    end
  end

  always_comb begin
    chain_o.claim_done = chain_i.claim_done | active_q;
    chain_o.match_done = chain_i.match_done | lo_hit | hi_hit;
    chain_o.free_done  = chain_i.free_done | ~active_q;
    chain_o.grant_idx  = chain_i.grant_idx | (claim_hit ? start_q[IDX_W-1:0] : '0);
  end

endmodule
`default_nettype wire

// File: rtl/core/fisa_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module fisa_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fisa_pkg::res_t   push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output fisa_pkg::res_t        out_data_o
);
  import fisa_pkg::*;

  res_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/free_interval_slot_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Free-slot allocator over a row of interval cells, one cell per [start,end) entry.
// Takes one beat per cycle while in_stall_o is low and returns exactly one
// result beat per input beat, in order through the result buffer. A claim grants
// the start of the first active cell; a release extends the first active cell it
// touches, else opens the first idle cell, else sets the sticky overflow flag.
// The cycle time is set by the priority ripple through the cell row
// (INTERVAL_ENTRIES cells). A two-beat result buffer keeps input flowing while a
// result waits to be taken; in_stall_o rises only when both beats are held.
module free_interval_slot_allocator_unit #(
  parameter int unsigned SLOT_COUNT       = fisa_pkg::SLOT_COUNT_DEF,
  parameter int unsigned INTERVAL_ENTRIES = fisa_pkg::INTERVAL_ENTRIES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [fisa_pkg::IDX_W-1:0]  release_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             granted_o,
  output logic [fisa_pkg::IDX_W-1:0]       granted_index_o,
  output logic                             table_overflow_o
);
  import fisa_pkg::*;

  localparam int unsigned CntW   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned BoundW = (CntW > IDX_W + 1) ? CntW : IDX_W + 1;

  chain_t chain [INTERVAL_ENTRIES+1];
  logic   accept, any_match, ovf_set, overflow_q, full;
  res_t   res, out_res;

  assign accept    = in_valid_i & ~full;
  assign in_stall_o = full;

  assign chain[0]  = '{claim_done: 1'b0, match_done: 1'b0, free_done: 1'b0,
                       grant_idx: '0};
  assign any_match = chain[INTERVAL_ENTRIES].match_done;

  for (genvar g = 0; g < INTERVAL_ENTRIES; g++) begin : g_cell
    fisa_cell #(
      .BoundW    (BoundW),
      .RstActive (1'(g == 0)),
      .RstEnd    ((g == 0) ? BoundW'(SLOT_COUNT) : BoundW'(0))
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .accept_i        (accept),
      .operation_i     (operation_i),
      .release_index_i (release_index_i),
      .any_match_i     (any_match),
      .chain_i         (chain[g]),
      .chain_o         (chain[g+1])
    );
  end

  assign ovf_set = accept & (operation_i == OP_RELEASE) & ~any_match
                 & ~chain[INTERVAL_ENTRIES].free_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_q <= 1'b0;
    end else if (ovf_set) begin
      overflow_q <= 1'b1;
    end
  end

  always_comb begin
    res.granted        = (operation_i == OP_CLAIM) & chain[INTERVAL_ENTRIES].claim_done;
    res.granted_index  = chain[INTERVAL_ENTRIES].grant_idx;
    res.table_overflow = overflow_q | ovf_set;
  end

  fisa_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign granted_o        = out_res.granted;
  assign granted_index_o  = out_res.granted_index;
  assign table_overflow_o = out_res.table_overflow;

endmodule
`default_nettype wire

// File: rtl/core/fisa_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module fisa_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        granted_o,
  input wire logic [fisa_pkg::IDX_W-1:0]  granted_index_o,
  input wire logic                        table_overflow_o
);

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat gave no result");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_idx_zero_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> granted_index_o == '0)
    else $error("index without grant");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_index_o)
      && $stable(granted_o) && $stable(table_overflow_o))
    else $error("stalled result changed");

endmodule

bind free_interval_slot_allocator_unit fisa_chk u_fisa_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .granted_o        (granted_o),
  .granted_index_o  (granted_index_o),
  .table_overflow_o (table_overflow_o)
);
`default_nettype wire

// File: tb/sv/slot_board_pkg.sv
`timescale 1ns / 1ps
package slot_board_pkg;
  import fisa_pkg::*;

  class slot_board;
    localparam int unsigned ENTRIES = INTERVAL_ENTRIES_DEF;

    logic [10:0] lo   [ENTRIES];
    logic [10:0] hi   [ENTRIES];
    bit          live [ENTRIES];
    bit          lost_flag;
    res_t        pending_res[$];
    int          mismatches;
    int          grants;
    int          refusals;
    int          releases;
    int          results;

    function new();
      for (int e = 0; e < ENTRIES; e++) begin
        lo[e]   = '0;
        hi[e]   = '0;
        live[e] = 1'b0;
      end
      hi[0]      = 11'(SLOT_COUNT_DEF);
      live[0]    = 1'b1;
      lost_flag  = 1'b0;
      mismatches = 0;
      grants     = 0;
      refusals   = 0;
      releases   = 0;
      results    = 0;
    endfunction

    function int free_slots();
      int total;
      total = 0;
      for (int e = 0; e < ENTRIES; e++) begin
        if (live[e]) total += int'(hi[e]) - int'(lo[e]);
      end
      return total;
    endfunction

    // accepted input beat: update the interval table and queue the result
    function void note_beat(input op_e op, input logic [IDX_W-1:0] idx,
                            output bit got, output logic [IDX_W-1:0] slot);
      res_t        r;
      bit          done;
      logic [10:0] s;
      got  = 1'b0;
      slot = '0;
      done = 1'b0;
      s    = {1'b0, idx};
      if (op == OP_CLAIM) begin
        for (int e = 0; e < ENTRIES; e++) begin
          if (live[e] && !done) begin
            slot  = lo[e][IDX_W-1:0];
            lo[e] = lo[e] + 11'd1;
            if (lo[e] >= hi[e]) live[e] = 1'b0;
            got  = 1'b1;
            done = 1'b1;
          end
        end
        if (got) grants++;
        else refusals++;
      end else begin
        releases++;
        for (int e = 0; e < ENTRIES; e++) begin
          if (live[e] && !done) begin
            if (s + 11'd1 == lo[e]) begin
              lo[e] = s;
              done  = 1'b1;
            end else if (hi[e] == s) begin
              hi[e] = s + 11'd1;
              done  = 1'b1;
            end
          end
        end
        for (int e = 0; e < ENTRIES; e++) begin
          if (!live[e] && !done) begin
            lo[e]   = s;
            hi[e]   = s + 11'd1;
            live[e] = 1'b1;
            done    = 1'b1;
          end
        end
        if (!done) lost_flag = 1'b1;
      end
      r.granted        = got;
      r.granted_index  = slot;
      r.table_overflow = lost_flag;
      pending_res.push_back(r);
    endfunction

    function void report(input string what, input logic [IDX_W-1:0] want,
                         input logic [IDX_W-1:0] seen);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
    endfunction

    function void check_beat(input logic g, input logic [IDX_W-1:0] gi, input logic ov);
      res_t want;
      if (pending_res.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got granted %0b index %0d ovf %0b",
                 $time, g, gi, ov);
        return;
      end
      want = pending_res.pop_front();
      results++;
      if (g !== want.granted) report("granted", IDX_W'(want.granted), IDX_W'(g));
      if (gi !== want.granted_index) report("granted_index", want.granted_index, gi);
      if (ov !== want.table_overflow)
        report("table_overflow", IDX_W'(want.table_overflow), IDX_W'(ov));
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fisa_pkg::*;
  import slot_board_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 64;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             operation_i     = 1'b0;
  logic [IDX_W-1:0] release_index_i = '0;
  logic             out_stall_i     = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             granted_o;
  logic [IDX_W-1:0] granted_index_o;
  logic             table_overflow_o;

  slot_board        board = new();
  logic [IDX_W-1:0] held[$];
  bit               steady   = 1'b0;
  bit               hold_req = 1'b0;
  int               idle_cycles = 0;

  free_interval_slot_allocator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .release_index_i  (release_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_o        (granted_o),
    .granted_index_o  (granted_index_o),
    .table_overflow_o (table_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_beat(input op_e op, input logic [IDX_W-1:0] idx);
    int               gap;
    bit               got;
    logic [IDX_W-1:0] slot;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    release_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(op, idx, got, slot);
    if (got) held.push_back(slot);
  endtask

  task automatic claim_slot();
    send_beat(OP_CLAIM, IDX_W'($urandom));
  endtask

  // mostly hands back a slot we hold; now and then a stray index
  task automatic release_some();
    int               k;
    logic [IDX_W-1:0] idx;
    if (held.size() == 0 || $urandom_range(0, 9) == 0) begin
      idx = IDX_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
    end else begin
      k   = $urandom_range(0, held.size() - 1);
      idx = held[k];
      held.delete(k);
    end
    send_beat(OP_RELEASE, idx);
  endtask

  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        n        = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        n = steady ? 0 : $urandom_range(0, 5);
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_beat(granted_o, granted_index_o, table_overflow_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first active entry wins, start/end growth, double release, top slot
    claim_slot();
    claim_slot();
    claim_slot();
    send_beat(OP_RELEASE, 10'd1);
    send_beat(OP_RELEASE, 10'd2);
    send_beat(OP_RELEASE, 10'd0);
    send_beat(OP_RELEASE, 10'd1023);
    send_beat(OP_RELEASE, 10'd1022);
    send_beat(OP_RELEASE, 10'd1023);
    send_beat(OP_RELEASE, 10'h155);
    send_beat(OP_RELEASE, 10'h2aa);
    send_beat(OP_RELEASE, 10'h156);
    send_beat(OP_RELEASE, 10'h2a9);
    claim_slot();
    claim_slot();
    claim_slot();
    send_beat(OP_RELEASE, 10'd0);
    claim_slot();

    // mixed traffic, fragments the table
    for (int i = 0; i < 250; i++) begin
      steady = (i >= 150 && i < 200);
      if (i == 60) hold_req = 1'b1;
      if ($urandom_range(0, 3) != 0) claim_slot();
      else release_some();
    end
    steady = 1'b0;

    // drain every free slot, then claim on an empty table
    n = 0;
    while (board.free_slots() != 0 && n < 2000) begin
      claim_slot();
      n++;
    end
    repeat (8) claim_slot();

    for (int i = 0; i < 80; i++) begin
      if ($urandom_range(0, 1) != 0) claim_slot();
      else release_some();
    end
    in_valid_i <= 1'b0;

    while (board.pending_res.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run: %0d result beats checked; %0d grants, %0d claims on an empty table, %0d releases.",
             board.results, board.grants, board.refusals, board.releases);
    $display("Overflow flag %s; %0d mismatches.",
             board.lost_flag ? "raised" : "never raised", board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
